FILE: design/assert_macros.svh
// Assertion helpers used by the FIR unit design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/oafft_pkg.sv
package oafft_pkg;

   localparam int FftPoints = 16;
   localparam int BlockLen  = 10;
   localparam int TapCount  = 7;
   localparam int NumTaps   = 7;
   localparam int TailLen   = TapCount - 1;
   localparam int AddrW     = 4;
   localparam int InvScale  = 65536 / FftPoints;

   typedef logic [31:0] word_type;
   typedef logic [AddrW-1:0] addr_type;

   typedef struct packed {
      word_type re;
      word_type im;
   } cplx_type;

   // Memory map of the working RAM (64-bit complex words).
   localparam int WorkBase = 0;   // 16 entries: transform buffer
   localparam int SpecBase = 16;  // 16 entries: filter spectrum
   localparam int ProdBase = 32;  // 16 entries: spectrum product
   localparam int TailBase = 48;  // tail, real part only
   localparam int RamDepth = 64;
   localparam int RamAddrW = 6;

   function automatic word_type qmul(input word_type a, input word_type b);
      logic signed [63:0] p;
      begin
         p = $signed(a) * $signed(b);
         qmul = p[47:16];
      end
   endfunction

   function automatic word_type tw_re(input logic [2:0] k);
      unique case (k)
         3'd0: tw_re = 32'sd65536;
         3'd1: tw_re = 32'sd60547;
         3'd2: tw_re = 32'sd46341;
         3'd3: tw_re = 32'sd25080;
         3'd4: tw_re = 32'sd0;
         3'd5: tw_re = -32'sd25080;
         3'd6: tw_re = -32'sd46341;
         default: tw_re = -32'sd60547;
      endcase
   endfunction

   function automatic word_type tw_im(input logic [2:0] k);
      unique case (k)
         3'd0: tw_im = 32'sd0;
         3'd1: tw_im = -32'sd25080;
         3'd2: tw_im = -32'sd46341;
         3'd3: tw_im = -32'sd60547;
         3'd4: tw_im = -32'sd65536;
         3'd5: tw_im = -32'sd60547;
         3'd6: tw_im = -32'sd46341;
         default: tw_im = -32'sd25080;
      endcase
   endfunction

   function automatic addr_type bitrev(input addr_type i);
      bitrev = {i[0], i[1], i[2], i[3]};
   endfunction

endpackage

FILE: design/overlap_add_fft_fir_unit.sv
// Overlap-add FIR: 7 Q16.16 taps, 10-sample blocks, 16-point fixed-point FFT.
// Samples 1..9 of a block are stored in a buffer. The tenth starts the
// block job run by one sequencer on a single 64-bit working RAM (one write,
// one registered read per cycle) and one butterfly unit. The job runs load,
// forward FFT, spectrum product, reload and inverse FFT; then 10 items
// leave as rsp_ready allows, and the tail words are saved. A tap write
// starts a spectrum rebuild; csr writes are to be only issued idle, which
// the user must ensure, and req_ready is low while a write is presented.
// After reset a clearing pass zeros the spectrum, product and tail entries
// while req_ready is low. No new sample is taken until a block job or
// rebuild is through.
`include "assert_macros.svh"
module overlap_add_fft_fir_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_in_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_sample,
   output logic        rsp_block_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_PASS_RD, ST_PASS_WR,
      ST_MUL, ST_SCALE, ST_EMIT_RD, ST_EMIT, ST_TAIL, ST_COPY
   } state_type;

   typedef enum logic [1:0] {
      JOB_SPEC, JOB_FWD, JOB_INV
   } job_type;

   state_type           state_ff, state_in;
   job_type             job_ff, job_in;
   oafft_pkg::word_type taps_ff [oafft_pkg::NumTaps];
   oafft_pkg::word_type blk_ff [oafft_pkg::BlockLen];
   logic [3:0]          fill_ff, fill_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [1:0]          stage_ff, stage_in;
   logic [2:0]          sub_ff, sub_in;
   oafft_pkg::cplx_type a_ff, a_in;
   oafft_pkg::word_type out_ff, out_in;
   logic                last_ff, last_in;
   logic                rv_ff, rv_in;

   logic                       we;
   logic [oafft_pkg::RamAddrW-1:0] wa, ra;
   oafft_pkg::cplx_type        wd, rd;
   oafft_pkg::cplx_type        b_in, sum, dif;
   oafft_pkg::word_type        w_re, w_im;

   oafft_ram #(.Width(64), .Depth(oafft_pkg::RamDepth)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd)
   );

   oafft_bfly u_bfly (
      .clock(clock), .a_in(a_ff), .b_in(b_in), .w_re_in(w_re), .w_im_in(w_im),
      .sum_out(sum), .dif_out(dif)
   );

   // Butterfly indexing: stage s has half-span h = 1<<s; butterfly j (0..7)
   // pairs p = group*2h + k and p+h, twiddle k*(8>>s).
   logic [2:0]  bj;
   logic [3:0]  hs, pa, pb;
   logic [2:0]  kk, tw;
   logic [5:0]  base;

   always_comb begin
      bj = cnt_ff[5:3];
      hs = 4'd1 << stage_ff;
      kk = bj & (hs[2:0] - 3'd1);
      pa = 4'(({1'b0, bj} >> stage_ff) << ({1'b0, stage_ff} + 3'd1)) | {1'b0, kk};
      pb = pa + hs;
      tw = 3'((kk << (2'd3 - stage_ff)));
      base = (job_ff == JOB_SPEC) ? 6'(oafft_pkg::SpecBase) : 6'(oafft_pkg::WorkBase);
   end

   // Per-butterfly micro sequence in ST_PASS_RD (sub_ff):
   // 0: read a  1: read b, latch a  2: b on rd -> mult  3-4: wait
   // 5: write sum; ST_PASS_WR writes dif.
   // The first stage works on bit-reversed data; LOAD writes reversed order.

   logic [3:0] ld_idx;
   oafft_pkg::word_type ld_val;

   always_comb begin
      ld_idx = cnt_ff[3:0];
      if (job_ff == JOB_SPEC) begin
         ld_val = (32'(ld_idx) < oafft_pkg::TapCount &&
                   32'(ld_idx) < oafft_pkg::NumTaps) ? taps_ff[ld_idx[2:0]] : '0;
      end else begin
         ld_val = (32'(ld_idx) < oafft_pkg::BlockLen) ? blk_ff[ld_idx] : '0;
      end
   end

   oafft_pkg::word_type pr_re, pr_im;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      stage_in = stage_ff;
      sub_in   = sub_ff;
      a_in     = a_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      rv_in    = rv_ff;
      we = 1'b0;
      wa = '0;
      wd = '0;
      ra = '0;
      b_in = rd;
      w_re = oafft_pkg::tw_re(tw);
      w_im = oafft_pkg::tw_im(tw);
      pr_re = '0;
      pr_im = '0;
      req_ready = (state_ff == ST_IDLE) && !rv_ff && !csr_wr_en;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            wa = 6'(oafft_pkg::SpecBase) + cnt_ff;
            if (cnt_ff == 6'(oafft_pkg::RamDepth - oafft_pkg::SpecBase - 1)) begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_IDLE: begin
            if (csr_wr_en && 32'(csr_index) < oafft_pkg::NumTaps) begin
               job_in = JOB_SPEC;
               state_in = ST_LOAD;
               cnt_in = '0;
            end else if (req_valid && req_ready) begin
               if (32'(fill_ff) == oafft_pkg::BlockLen - 1) begin
                  fill_in = '0;
                  job_in = JOB_FWD;
                  state_in = ST_LOAD;
                  cnt_in = '0;
               end else begin
                  fill_in = fill_ff + 4'd1;
               end
            end
         end
         ST_LOAD: begin
            we = 1'b1;
            wa = base + 6'(oafft_pkg::bitrev(ld_idx));
            wd.re = ld_val;
            wd.im = '0;
            if (ld_idx == 4'd15) begin
               state_in = ST_PASS_RD;
               stage_in = '0;
               sub_in = '0;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_PASS_RD: begin
            unique case (sub_ff)
               3'd0: ra = base + 6'(pa);
               3'd1: ra = base + 6'(pb);
               default: ra = base + 6'(pb);
            endcase
            if (sub_ff == 3'd1) a_in = rd;
            if (sub_ff == 3'd5) begin
               we = 1'b1; wa = base + 6'(pa); wd = sum;
            end
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd5) state_in = ST_PASS_WR;
         end
         ST_PASS_WR: begin
            b_in = '0;
            we = 1'b1;
            wa = base + 6'(pb);
            wd = dif;
            sub_in = '0;
            state_in = ST_PASS_RD;
            if (bj == 3'd7) begin
               cnt_in = '0;
               if (stage_ff == 2'd3) begin
                  unique case (job_ff)
                     JOB_SPEC: state_in = ST_COPY;
                     JOB_FWD:  state_in = ST_MUL;
                     default:  state_in = ST_EMIT_RD;
                  endcase
               end else begin
                  stage_in = stage_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + 6'd8;
            end
         end
         ST_COPY: begin
            // Spectrum is transformed in place at SpecBase; nothing to move.
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            // sub 0: read X[i]; sub 1: read S[i], latch X; sub 2: mult;
            // sub 3: wait; sub 4: write conj product.
            unique case (sub_ff)
               3'd0: ra = 6'(oafft_pkg::WorkBase) + 6'(cnt_ff[3:0]);
               default: ra = 6'(oafft_pkg::SpecBase) + 6'(cnt_ff[3:0]);
            endcase
            if (sub_ff == 3'd1) a_in = rd;
            w_re = a_ff.re;
            w_im = a_ff.im;
            b_in = rd;
            pr_re = sum.re;
            pr_im = sum.im;
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               we = 1'b1;
               wa = 6'(oafft_pkg::ProdBase) + 6'(cnt_ff[3:0]);
               wd.re = pr_re - a_ff.re;
               wd.im = a_ff.im - pr_im;
               sub_in = '0;
               if (cnt_ff[3:0] == 4'd15) begin
                  cnt_in = '0;
                  state_in = ST_SCALE;
                  job_in = JOB_INV;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         ST_SCALE: begin
            if (job_ff == JOB_INV && sub_ff != 3'd7) begin
               // reload product into work area, bit-reversed, then inverse FFT
               ra = 6'(oafft_pkg::ProdBase) + 6'(cnt_ff[3:0]);
               sub_in = sub_ff == 3'd1 ? 3'd0 : 3'd1;
               if (sub_ff == 3'd1) begin
                  we = 1'b1;
                  wa = 6'(oafft_pkg::bitrev(cnt_ff[3:0]));
                  wd = rd;
                  if (cnt_ff[3:0] == 4'd15) begin
                     cnt_in = '0; stage_in = '0; sub_in = 3'd7;
                     state_in = ST_PASS_RD;
                  end else begin
                     cnt_in = cnt_ff + 6'd1;
                  end
               end
            end else begin
               sub_in = '0;
               cnt_in = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            ra = 6'(cnt_ff[3:0]);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            ra = (32'(cnt_ff) < oafft_pkg::TailLen) ?
                 6'(oafft_pkg::TailBase) + cnt_ff : 6'(cnt_ff[3:0]);
            unique case (sub_ff)
               3'd0: begin
                  // result word is on rd this cycle; a tail word follows for the first TailLen items
                  a_in = rd;
                  sub_in = 3'd1;
               end
               default: begin
                  if (!rv_ff || rsp_ready) begin
                     out_in = oafft_pkg::qmul(a_ff.re, 32'(oafft_pkg::InvScale))
                              + ((32'(cnt_ff) < oafft_pkg::TailLen) ? rd.re : 32'd0);
                     last_in = 32'(cnt_ff) == oafft_pkg::BlockLen - 1;
                     rv_in = 1'b1;
                     sub_in = '0;
                     if (32'(cnt_ff) == oafft_pkg::BlockLen - 1) begin
                        cnt_in = '0;
                        state_in = ST_TAIL;
                     end else begin
                        cnt_in = cnt_ff + 6'd1;
                        state_in = ST_EMIT_RD;
                     end
                  end
               end
            endcase
         end
         ST_TAIL: begin
            // sub even: read result word; sub odd: write scaled tail word.
            ra = 6'((32'(cnt_ff) + oafft_pkg::BlockLen) % oafft_pkg::FftPoints);
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd1) begin
               we = 1'b1;
               wa = 6'(oafft_pkg::TailBase) + cnt_ff;
               wd.re = oafft_pkg::qmul(rd.re, 32'(oafft_pkg::InvScale));
               wd.im = '0;
               sub_in = '0;
               if (32'(cnt_ff) == oafft_pkg::TailLen - 1) begin
                  state_in = ST_IDLE;
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff + 6'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         job_ff   <= JOB_SPEC;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         stage_ff <= '0;
         sub_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < oafft_pkg::NumTaps; i++) taps_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         stage_ff <= stage_in;
         sub_ff   <= (state_ff == ST_SCALE && state_in == ST_PASS_RD) ? 3'd0 : sub_in;
         rv_ff    <= rv_in;
         if (csr_wr_en && 32'(csr_index) < oafft_pkg::NumTaps) begin
            taps_ff[csr_index] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      out_ff  <= out_in;
      last_ff <= last_in;
      if (req_valid && req_ready) blk_ff[fill_ff] <= req_in_sample;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_out_sample = out_ff;
   assign rsp_block_last = last_ff;

   `ASSERT_CLK(a_no_req_busy, clock, reset, !(req_ready && state_ff != ST_IDLE), "ready while busy")
   `ASSERT_CLK(a_fill_range, clock, reset, 32'(fill_ff) < oafft_pkg::BlockLen, "fill out of range")
   `ASSERT_NEXT(a_last_idle, clock, reset, rv_ff && last_ff && rsp_ready, !rv_ff, "item after last")

endmodule

FILE: design/oafft_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module oafft_ram #(
   parameter int Width = 64,
   parameter int Depth = 64,
   parameter int AddrW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/oafft_bfly.sv
// Radix-2 butterfly on a shared complex multiplier: two stages.
// Stage 1 registers the four partial products, stage 2 forms a+w*b, a-w*b.
module oafft_bfly (
   input  logic                clock,
   input  oafft_pkg::cplx_type a_in,
   input  oafft_pkg::cplx_type b_in,
   input  oafft_pkg::word_type w_re_in,
   input  oafft_pkg::word_type w_im_in,
   output oafft_pkg::cplx_type sum_out,
   output oafft_pkg::cplx_type dif_out
);

   oafft_pkg::word_type rr_ff, ii_ff, ri_ff, ir_ff;
   oafft_pkg::cplx_type a_ff;
   oafft_pkg::word_type vr, vi;

   always_ff @(posedge clock) begin
      rr_ff <= oafft_pkg::qmul(w_re_in, b_in.re);
      ii_ff <= oafft_pkg::qmul(w_im_in, b_in.im);
      ri_ff <= oafft_pkg::qmul(w_re_in, b_in.im);
      ir_ff <= oafft_pkg::qmul(w_im_in, b_in.re);
      a_ff  <= a_in;
   end

   always_comb begin
      vr = rr_ff - ii_ff;
      vi = ri_ff + ir_ff;
      sum_out.re = a_ff.re + vr;
      sum_out.im = a_ff.im + vi;
      dif_out.re = a_ff.re - vr;
      dif_out.im = a_ff.im - vi;
   end

endmodule

FILE: sim/overlap_add_checker.sv
`timescale 1ns / 100ps
module overlap_add_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_in_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_out_sample,
   input  logic        rsp_block_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef oafft_pkg::word_type vec_type [oafft_pkg::FftPoints];

   typedef struct {
      oafft_pkg::word_type sample;
      logic                last;
   } filt_out_type;

   localparam oafft_pkg::word_type TwRe [8] = '{32'sd65536, 32'sd60547, 32'sd46341,
      32'sd25080, 32'sd0, -32'sd25080, -32'sd46341, -32'sd60547};
   localparam oafft_pkg::word_type TwIm [8] = '{32'sd0, -32'sd25080, -32'sd46341,
      -32'sd60547, -32'sd65536, -32'sd60547, -32'sd46341, -32'sd25080};
   localparam oafft_pkg::word_type InvScale = 32'd4096;

   oafft_pkg::word_type taps [oafft_pkg::NumTaps];
   vec_type             spec_re, spec_im;
   oafft_pkg::word_type tail [oafft_pkg::TailLen];
   oafft_pkg::word_type blk [oafft_pkg::BlockLen];
   int                  fill;
   filt_out_type        filt_q [$];

   assign pending_count = filt_q.size();

   function automatic oafft_pkg::word_type fx_mul(oafft_pkg::word_type a,
                                                  oafft_pkg::word_type b);
      logic signed [63:0] p;
      p = $signed(a) * $signed(b);
      return p[47:16];
   endfunction

   task automatic cx_mul(input oafft_pkg::word_type ar, ai, br, bi,
                         output oafft_pkg::word_type yr, yi);
      yr = fx_mul(ar, br) - fx_mul(ai, bi);
      yi = fx_mul(ar, bi) + fx_mul(ai, br);
   endtask

   task automatic butterfly(inout vec_type re, inout vec_type im, input int a, b, tw);
      oafft_pkg::word_type vr, vi, ur, ui;
      ur = re[a];
      ui = im[a];
      cx_mul(TwRe[tw], TwIm[tw], re[b], im[b], vr, vi);
      re[a] = ur + vr; im[a] = ui + vi;
      re[b] = ur - vr; im[b] = ui - vi;
   endtask

   task automatic fft16(inout vec_type re, inout vec_type im);
      vec_type             tr, ti;
      oafft_pkg::word_type u0r, u0i, u1r, u1i, v0r, v0i, t1r, t1i;
      logic [3:0]          r;
      for (int i = 0; i < 16; i++) begin
         r = {i[0], i[1], i[2], i[3]};
         tr[i] = re[r];
         ti[i] = im[r];
      end
      re = tr;
      im = ti;
      for (int i = 0; i < 16; i += 2) begin
         u0r = re[i]; u0i = im[i]; u1r = re[i+1]; u1i = im[i+1];
         re[i] = u0r + u1r; im[i] = u0i + u1i;
         re[i+1] = u0r - u1r; im[i+1] = u0i - u1i;
      end
      // second stage twiddle is -j: swap and negate
      for (int i = 0; i < 16; i += 4) begin
         u0r = re[i]; u0i = im[i]; u1r = re[i+1]; u1i = im[i+1];
         v0r = re[i+2]; v0i = im[i+2];
         t1r = im[i+3]; t1i = 32'd0 - re[i+3];
         re[i] = u0r + v0r; im[i] = u0i + v0i;
         re[i+1] = u1r + t1r; im[i+1] = u1i + t1i;
         re[i+2] = u0r - v0r; im[i+2] = u0i - v0i;
         re[i+3] = u1r - t1r; im[i+3] = u1i - t1i;
      end
      for (int i = 0; i < 16; i += 8)
         for (int k = 0; k < 4; k++)
            butterfly(re, im, i + k, i + k + 4, 2 * k);
      for (int k = 0; k < 8; k++)
         butterfly(re, im, k, k + 8, k);
   endtask

   task automatic rebuild_spectrum();
      for (int i = 0; i < 16; i++) begin
         spec_re[i] = (i < oafft_pkg::TapCount && i < oafft_pkg::NumTaps) ? taps[i] : '0;
         spec_im[i] = '0;
      end
      fft16(spec_re, spec_im);
   endtask

   task automatic filter_block();
      vec_type             xr, xi;
      oafft_pkg::word_type yr, yi;
      filt_out_type        o;
      for (int i = 0; i < 16; i++) begin
         xr[i] = (i < oafft_pkg::BlockLen) ? blk[i] : '0;
         xi[i] = '0;
      end
      fft16(xr, xi);
      for (int i = 0; i < 16; i++) begin
         cx_mul(xr[i], xi[i], spec_re[i], spec_im[i], yr, yi);
         xr[i] = yr;
         xi[i] = 32'd0 - yi;
      end
      fft16(xr, xi);
      for (int i = 0; i < 16; i++) xr[i] = fx_mul(xr[i], InvScale);
      for (int i = 0; i < oafft_pkg::BlockLen; i++) begin
         o.sample = xr[i % 16];
         if (i < oafft_pkg::TailLen) o.sample = o.sample + tail[i];
         o.last = (i == oafft_pkg::BlockLen - 1);
         filt_q.push_back(o);
      end
      // tail wraps around the transform when the block is long
      for (int i = 0; i < oafft_pkg::TailLen; i++)
         tail[i] = xr[(oafft_pkg::BlockLen + i) % 16];
   endtask

   always @(posedge clock) begin
      filt_out_type exp_o;
      if (reset) begin
         for (int i = 0; i < oafft_pkg::NumTaps; i++) taps[i] = '0;
         for (int i = 0; i < 16; i++) begin
            spec_re[i] = '0;
            spec_im[i] = '0;
         end
         for (int i = 0; i < oafft_pkg::TailLen; i++) tail[i] = '0;
         fill = 0;
         filt_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en && csr_index < oafft_pkg::NumTaps) begin
            taps[csr_index] = csr_wdata;
            rebuild_spectrum();
         end
         if (rsp_valid && rsp_ready) begin
            if (filt_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected item out_sample=%h block_last=%b",
                           rsp_out_sample, rsp_block_last);
            end else begin
               exp_o = filt_q.pop_front();
               if (rsp_out_sample !== exp_o.sample || rsp_block_last !== exp_o.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: out_sample exp %h got %h, block_last exp %b got %b",
                              exp_o.sample, rsp_out_sample, exp_o.last, rsp_block_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            blk[fill] = req_in_sample;
            fill++;
            if (fill == oafft_pkg::BlockLen) begin
               fill = 0;
               filter_block();
            end
         end
      end
   end

endmodule

FILE: sim/tb_overlap_add_fft_fir_unit.sv
`timescale 1ns / 100ps
module tb_overlap_add_fft_fir_unit;

   localparam int IdleWait   = 700;
   localparam int StallLimit = 20000;
   localparam logic [2:0] BadTapIdx = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_in_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_sample;
   logic        rsp_block_last;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          idle_on = 1'b1;
   int          stall_cnt = 0;
   int          rsp_hold = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   overlap_add_fft_fir_unit u_top (.*);

   overlap_add_checker u_chk (.*);

   // result-side backpressure in bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         stall_cnt <= 0;
      else
         stall_cnt <= stall_cnt + 1;
      if (stall_cnt > StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic [31:0] s);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_and_settle();
      if (req_valid) req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (IdleWait) @(posedge clock);
   endtask

   task automatic write_tap(input logic [2:0] idx, input logic [31:0] val);
      drain_and_settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 262143)) - 131072);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 8388607)) - 4194304);
      endcase
   endfunction

   function automatic logic [31:0] rand_tap();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 131071)) - 65536);
      endcase
   endfunction

   initial begin
      logic [31:0] dir_items [20] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
         32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
         32'hAAAA_AAAA, 32'h0000_8000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
         32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         32'h0000_0000, 32'h0000_0000};
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero taps: output is the zero filter
      for (int i = 0; i < 10; i++) send_sample(dir_items[i]);
      // unit impulse response, plus ignored out-of-range index
      write_tap(3'd0, 32'h0001_0000);
      write_tap(BadTapIdx, 32'h1234_5678);
      for (int i = 10; i < 20; i++) send_sample(dir_items[i]);
      // extreme taps
      for (int t = 0; t < oafft_pkg::NumTaps; t++)
         write_tap(3'(t), (t % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      for (int i = 0; i < 5; i++) send_sample(dir_items[i]);
      // tap write with a partial block pending
      write_tap(3'd6, 32'hFFFF_FFFF);
      for (int i = 5; i < 10; i++) send_sample(dir_items[i]);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 4) idle_on = 1'b0;
         if (ph == 2) begin
            write_tap(3'($urandom_range(0, oafft_pkg::NumTaps - 1)), rand_tap());
         end else begin
            for (int t = 0; t < oafft_pkg::NumTaps; t++) write_tap(3'(t), rand_tap());
            if ($urandom_range(0, 1)) write_tap(BadTapIdx, $urandom());
         end
         n = $urandom_range(55, 65);
         for (int i = 0; i < n; i++) send_sample(rand_sample());
      end
      // complete any partial block; the same fill level is left over
      for (int i = 0; i < oafft_pkg::BlockLen; i++) send_sample(rand_sample());
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (IdleWait) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
